// ===== sv/tli_pkg.sv =====
// Shared widths, sizes and codes of the table linear interpolator.
package tli_pkg;

  localparam int DataW     = 32;
  localparam int ProdW     = 2 * DataW;
  localparam int StepW     = $clog2(ProdW);
  localparam int MaxPoints = 256;
  localparam int PtrW      = $clog2(MaxPoints);
  localparam int CntW      = PtrW + 1;
  localparam int StatW     = 3;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } tli_op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_BEFORE   = 3'd1,
    ST_DISABLED = 3'd2,
    ST_EXTRAP   = 3'd3,
    ST_FEW      = 3'd4,
    ST_EQUAL    = 3'd5,
    ST_LOADED   = 3'd6,
    ST_FULL     = 3'd7
  } tli_status_e;

endpackage

// ===== sv/tli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tli_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tli_muldiv.sv =====
// Bit-serial unsigned multiply followed by restoring division, one bit per cycle.
module tli_muldiv
  import tli_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] mcand_i,
  input  logic [DataW-1:0] mplier_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [ProdW-1:0] quot_o
);

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  md_state_e        state_q;
  logic [StepW-1:0] cnt_q;
  logic             done_q;

  logic [DataW-1:0] hi_q;
  logic [ProdW-1:0] lo_q;
  logic [DataW-1:0] mcand_q;
  logic [DataW-1:0] dvs_q;

  logic [DataW:0]   mul_sum;
  logic [DataW+1:0] trial;
  logic             ge;
  logic             mul_last;
  logic             div_last;

  // hi_q is the upper product half while multiplying and the remainder while dividing
  assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : {(DataW+1){1'b0}});
  assign trial    = {1'b0, hi_q, lo_q[ProdW-1]} - {2'b00, dvs_q};
  assign ge       = ~trial[DataW+1];
  assign mul_last = (cnt_q == StepW'(DataW - 1));
  assign div_last = (cnt_q == StepW'(ProdW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        MD_IDLE: begin
          if (start_i) begin
            cnt_q   <= '0;
            state_q <= MD_MUL;
          end
        end
        MD_MUL: begin
          cnt_q <= mul_last ? '0 : cnt_q + StepW'(1);
          if (mul_last) begin
            state_q <= MD_DIV;
          end
        end
        MD_DIV: begin
          cnt_q <= cnt_q + StepW'(1);
          if (div_last) begin
            done_q  <= 1'b1;
            state_q <= MD_IDLE;
          end
        end
        default: state_q <= MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          hi_q    <= '0;
          lo_q    <= {{DataW{1'b0}}, mplier_i};
          mcand_q <= mcand_i;
          dvs_q   <= divisor_i;
        end
      end
      MD_MUL: begin
        if (mul_last) begin
          // product becomes the dividend, remainder starts at zero
          hi_q <= '0;
          lo_q <= {mul_sum, lo_q[DataW-1:1]};
        end else begin
          hi_q <= mul_sum[DataW:1];
          lo_q <= {lo_q[ProdW-1:DataW], mul_sum[0], lo_q[DataW-1:1]};
        end
      end
      MD_DIV: begin
        hi_q <= ge ? trial[DataW-1:0] : {hi_q[DataW-2:0], lo_q[ProdW-1]};
        lo_q <= {lo_q[ProdW-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = lo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == MD_IDLE)
    else $error("muldiv started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == MD_DIV)
    else $error("done without a division pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MD_DIV |-> hi_q < dvs_q)
    else $error("remainder not below divisor");

endmodule

// ===== sv/table_linear_interpolator_unit.sv =====
// Piecewise-linear pressure-over-time lookup with a forward-only segment cursor.
//
// Loads (op 0) append a (time, pressure) point in signed Q16.16 and rewind the cursor;
// a load into a full table of 256 points is dropped with status full. Queries (op 1)
// return the pressure on the current segment's line, moving the cursor forward while
// the query time lies past the segment end, and extending the last segment beyond the
// final point. Every transaction in yields exactly one transaction out. The table is
// held in two RAMs that are only read below the fill count, so no clearing pass runs
// after reset. Rate: one item at a time, plus any wait for the output register to
// drain. A query that does not end early (disabled, too few points, before start) and
// whose segment has distinct times takes one time-RAM read per step of the cursor's
// search, then a bit-serial 32 x 32 multiply and a 64 / 32 restoring division in
// the shared multiply-divide unit.
module table_linear_interpolator_unit
  import tli_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic signed [DataW-1:0] time_value_i,
  input  logic signed [DataW-1:0] pressure_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] pressure_out_o,
  output logic [StatW-1:0]        status_o,
  output logic                    saturated_o
);

  localparam int SumW   = DataW + 3;
  localparam int SatBit = DataW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SEARCH,
    S_READ1,
    S_READ2,
    S_CALC,
    S_FIN
  } state_e;

  // Control and registered outputs
  state_e                   state_q;
  logic                     enable_q;
  logic [CntW-1:0]          count_q;
  logic [PtrW-1:0]          cur_q;
  logic                     out_valid_q;
  logic signed [DataW-1:0]  out_p_q;
  tli_status_e              out_st_q;
  logic                     out_sat_q;

  // Datapath and pending result
  logic signed [DataW-1:0]  t_q;
  logic signed [DataW-1:0]  t1_q;
  logic signed [DataW-1:0]  t2_q;
  logic signed [DataW-1:0]  p1_q;
  logic                     neg_q;
  logic signed [DataW-1:0]  pres_q;
  tli_status_e              pst_q;
  logic                     psat_q;

  logic                     in_accept;
  logic                     is_load;
  logic                     full;
  logic                     tab_we;
  logic [PtrW-1:0]          last;
  logic [PtrW-1:0]          cur_clamp;
  logic                     adv;
  logic [PtrW-1:0]          t_raddr;
  logic [PtrW-1:0]          p_raddr;
  logic [DataW-1:0]         t_rdata;
  logic [DataW-1:0]         p_rdata;

  logic [DataW:0]           dp;
  logic [DataW:0]           dx;
  logic [DataW:0]           dt;
  logic                     neg_d;
  logic                     equal;
  logic                     extrap;

  logic                     md_start;
  logic                     md_done;
  logic [ProdW-1:0]         quot;
  logic                     qbig;
  logic [SumW-1:0]          p1_ext;
  logic [SumW-1:0]          q_ext;
  logic [SumW-1:0]          sum;
  logic                     fits;
  logic signed [DataW-1:0]  calc_res;
  logic                     calc_sat;

  localparam logic [DataW-1:0] PMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] PMin = {1'b1, {(DataW-1){1'b0}}};

  function automatic logic [DataW-1:0] mag(input logic [DataW:0] v);
    logic [DataW:0] n;
    n = -v;
    return v[DataW] ? n[DataW-1:0] : v[DataW-1:0];
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign is_load    = (op_i == OP_LOAD);
  assign full       = (count_q == CntW'(MaxPoints));
  assign tab_we     = in_accept & is_load & ~full;

  // last segment index; only meaningful once two points are stored
  assign last      = PtrW'(count_q - CntW'(2));
  assign cur_clamp = (cur_q > last) ? last : cur_q;
  assign adv       = (state_q == S_SEARCH) && (cur_q < last)
                     && (t_q > $signed(t_rdata));

  // Time RAM: first point, then segment ends during the search, then segment start
  always_comb begin
    case (state_q)
      S_FIRST:  t_raddr = cur_clamp + PtrW'(1);
      S_SEARCH: t_raddr = adv ? cur_q + PtrW'(2) : cur_q;
      default:  t_raddr = '0;
    endcase
  end

  // Pressure RAM: segment start while searching, then segment end in S_READ1
  assign p_raddr = (state_q == S_READ1) ? cur_q + PtrW'(1) : cur_q;

  tli_ram #(
    .Width(DataW),
    .Depth(MaxPoints)
  ) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(count_q[PtrW-1:0]),
    .wdata_i(time_value_i),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  tli_ram #(
    .Width(DataW),
    .Depth(MaxPoints)
  ) u_pressure_ram (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(count_q[PtrW-1:0]),
    .wdata_i(pressure_value_i),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  // Segment differences, valid in S_READ2 where p_rdata holds the end pressure
  assign dp = {p_rdata[DataW-1], p_rdata} - {p1_q[DataW-1], p1_q};
  assign dx = {t_q[DataW-1], t_q} - {t1_q[DataW-1], t1_q};
  assign dt = {t2_q[DataW-1], t2_q} - {t1_q[DataW-1], t1_q};

  // a zero product carries no sign
  assign neg_d  = (dp[DataW] ^ dx[DataW] ^ dt[DataW]) && (dp != '0) && (dx != '0);
  assign equal  = (t2_q == t1_q);
  assign extrap = (cur_q == last) && (t_q > t2_q);

  assign md_start = (state_q == S_READ2) && !equal;

  tli_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .mcand_i  (mag(dp)),
    .mplier_i (mag(dx)),
    .divisor_i(mag(dt)),
    .done_o   (md_done),
    .quot_o   (quot)
  );

  // Quotient above 2^33 saturates outright; otherwise add to the start pressure and clamp
  assign qbig   = (|quot[ProdW-1:SatBit+1]) | (quot[SatBit] & (|quot[SatBit-1:0]));
  assign p1_ext = {{(SumW-DataW){p1_q[DataW-1]}}, p1_q};
  assign q_ext  = {{(SumW-SatBit-1){1'b0}}, quot[SatBit:0]};
  assign sum    = neg_q ? p1_ext - q_ext : p1_ext + q_ext;
  assign fits   = (&sum[SumW-1:DataW-1]) | ~(|sum[SumW-1:DataW-1]);

  always_comb begin
    if (qbig) begin
      calc_res = neg_q ? PMin : PMax;
      calc_sat = 1'b1;
    end else if (!fits) begin
      calc_res = sum[SumW-1] ? PMin : PMax;
      calc_sat = 1'b1;
    end else begin
      calc_res = sum[DataW-1:0];
      calc_sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      enable_q    <= 1'b1;
      count_q     <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      out_p_q     <= '0;
      out_st_q    <= ST_OK;
      out_sat_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      // drop the drained result; the finish state refills the register itself
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (is_load) begin
              // append and rewind; drop the point when full
              if (!full) begin
                count_q <= count_q + CntW'(1);
                cur_q   <= '0;
              end
              state_q <= S_FIN;
            end else if (!enable_q || count_q < CntW'(2)) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          if (t_q > $signed(t_rdata)) begin
            cur_q   <= cur_clamp;
            state_q <= S_SEARCH;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_SEARCH: begin
          if (adv) begin
            cur_q <= cur_q + PtrW'(1);
          end else begin
            state_q <= S_READ1;
          end
        end
        S_READ1: state_q <= S_READ2;
        S_READ2: state_q <= equal ? S_FIN : S_CALC;
        S_CALC: begin
          if (md_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_p_q     <= pres_q;
            out_st_q    <= pst_q;
            out_sat_q   <= psat_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      t_q <= time_value_i;
    end
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          pres_q <= '0;
          psat_q <= 1'b0;
          if (is_load) begin
            pst_q <= full ? ST_FULL : ST_LOADED;
          end else begin
            pst_q <= !enable_q ? ST_DISABLED : ST_FEW;
          end
        end
      end
      S_FIRST: pst_q <= ST_BEFORE;
      S_SEARCH: begin
        if (!adv) begin
          t2_q <= t_rdata;
        end
      end
      S_READ1: begin
        t1_q <= t_rdata;
        p1_q <= p_rdata;
      end
      S_READ2: begin
        neg_q <= neg_d;
        if (equal) begin
          pres_q <= p1_q;
          pst_q  <= ST_EQUAL;
        end else begin
          pst_q <= extrap ? ST_EXTRAP : ST_OK;
        end
      end
      S_CALC: begin
        if (md_done) begin
          pres_q <= calc_res;
          psat_q <= calc_sat;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign pressure_out_o = out_p_q;
  assign status_o       = out_st_q;
  assign saturated_o    = out_sat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPoints))
    else $error("point count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CntW'(2) |-> cur_q <= last)
    else $error("cursor past last segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && is_load && !full |=> count_q == $past(count_q) + CntW'(1) && cur_q == '0)
    else $error("load did not append and rewind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_FIN)
    else $error("result issued outside finish state");

endmodule

// ===== test/lookup_checker.sv =====
// Checker for the table linear interpolator: mirrors the table and scores every result.
`timescale 1ns / 1ps

module lookup_checker
  import tli_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    op_i,
  input  logic signed [DataW-1:0] time_value_i,
  input  logic signed [DataW-1:0] pressure_value_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [DataW-1:0] pressure_out_i,
  input  logic [StatW-1:0]        status_i,
  input  logic                    saturated_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [DataW-1:0] pressure;
    tli_status_e             status;
    logic                    saturated;
  } lookup_result_t;

  localparam longint PresMax = 64'sh7FFF_FFFF;
  localparam longint PresMin = -64'sh8000_0000;

  logic signed [DataW-1:0] time_mem [MaxPoints];
  logic signed [DataW-1:0] pres_mem [MaxPoints];
  int unsigned             n_points;
  int unsigned             cursor;
  logic                    enable_q;
  lookup_result_t          outstanding_lookups [$];

  // Apply one transaction to the mirrored table and return the pressure it yields.
  function automatic lookup_result_t lookup_pressure(tli_op_e kind,
                                                     logic signed [DataW-1:0] t,
                                                     logic signed [DataW-1:0] p);
    lookup_result_t r;
    longint         tq, t1, t2, p1, p2, dp, dx, dt, res;
    bit [63:0]      mdp, mdx, mdt, quo;
    bit             neg;
    int unsigned    last;
    r = '{pressure: '0, status: ST_OK, saturated: 1'b0};
    if (kind == OP_LOAD) begin
      if (n_points >= MaxPoints) begin
        r.status = ST_FULL;
      end else begin
        time_mem[n_points] = t;
        pres_mem[n_points] = p;
        n_points++;
        cursor = 0;
        r.status = ST_LOADED;
      end
      return r;
    end
    if (!enable_q) begin
      r.status = ST_DISABLED;
      return r;
    end
    if (n_points < 2) begin
      r.status = ST_FEW;
      return r;
    end
    tq = t;
    if (tq <= longint'(time_mem[0])) begin
      r.status = ST_BEFORE;
      return r;
    end
    last = n_points - 2;
    if (cursor > last) cursor = last;
    while (cursor < last && tq > longint'(time_mem[cursor + 1])) cursor++;
    t1 = time_mem[cursor];
    t2 = time_mem[cursor + 1];
    p1 = pres_mem[cursor];
    p2 = pres_mem[cursor + 1];
    if (t2 == t1) begin
      r.pressure = p1[DataW-1:0];
      r.status   = ST_EQUAL;
      return r;
    end
    r.status = (cursor == last && tq > t2) ? ST_EXTRAP : ST_OK;
    dp  = p2 - p1;
    dx  = tq - t1;
    dt  = t2 - t1;
    neg = ((dp < 0) != (dx < 0)) != (dt < 0);
    if (dp == 0 || dx == 0) neg = 1'b0;
    mdp = (dp < 0) ? -dp : dp;
    mdx = (dx < 0) ? -dx : dx;
    mdt = (dt < 0) ? -dt : dt;
    quo = (mdp * mdx) / mdt;
    if (quo > 64'h2_0000_0000) begin
      r.saturated = 1'b1;
      res = neg ? PresMin : PresMax;
    end else begin
      res = neg ? p1 - longint'(quo) : p1 + longint'(quo);
      if (res > PresMax) begin
        res = PresMax;
        r.saturated = 1'b1;
      end else if (res < PresMin) begin
        res = PresMin;
        r.saturated = 1'b1;
      end
    end
    r.pressure = res[DataW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      n_points         = 0;
      cursor           = 0;
      enable_q         = 1'b1;
      mismatch_count_o = 0;
      outstanding_lookups.delete();
    end else begin
      if (cfg_we_i) enable_q = cfg_wdata_i;
      // score the output first so a result never pairs with the item accepted on this edge
      if (out_valid_i && out_ready_i) begin
        if (outstanding_lookups.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: result with nothing outstanding: pressure %h status %0d sat %0d",
                     $realtime, pressure_out_i, status_i, saturated_i);
          mismatch_count_o++;
        end else begin
          want = outstanding_lookups.pop_front();
          if (pressure_out_i !== want.pressure || status_i !== want.status ||
              saturated_i !== want.saturated) begin
            if (mismatch_count_o < 10)
              $display("%0t: mismatch want/got: pressure %h/%h status %0d/%0d sat %0d/%0d",
                       $realtime, want.pressure, pressure_out_i, want.status, status_i,
                       want.saturated, saturated_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        outstanding_lookups = {outstanding_lookups,
                               lookup_pressure(tli_op_e'(op_i), time_value_i,
                                               pressure_value_i)};
    end
    pending_o = outstanding_lookups.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the interpolator testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
  import tli_pkg::*;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    cfg_we         = 1'b0;
  logic                    cfg_wdata      = 1'b1;
  logic                    in_valid       = 1'b0;
  logic                    in_ready;
  logic                    op             = OP_LOAD;
  logic signed [DataW-1:0] time_value     = '0;
  logic signed [DataW-1:0] pressure_value = '0;
  logic                    out_valid;
  logic                    out_ready      = 1'b0;
  logic signed [DataW-1:0] pressure_out;
  logic [StatW-1:0]        status;
  logic                    saturated;
  int                      mismatches;
  int                      pending;

  // Stimulus bookkeeping: times of the points the table holds, in load order.
  int point_time [$];
  int items_sent  = 0;
  bit sender_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  table_linear_interpolator_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .time_value_i    (time_value),
    .pressure_value_i(pressure_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pressure_out_o  (pressure_out),
    .status_o        (status),
    .saturated_o     (saturated)
  );

  lookup_checker lookup_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .op_i            (op),
    .time_value_i    (time_value),
    .pressure_value_i(pressure_value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .pressure_out_i  (pressure_out),
    .status_i        (status),
    .saturated_i     (saturated),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  // Offer one transaction, idling a random number of cycles first; returns at the
  // falling edge after acceptance. Valid stays high across back-to-back items.
  task automatic send(tli_op_e kind, logic [DataW-1:0] t, logic [DataW-1:0] p);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    op             <= kind;
    time_value     <= t;
    pressure_value <= p;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    items_sent++;
    // switch between idling and full-rate stretches now and then
    if (items_sent % 50 == 0) sender_calm = ($urandom_range(0, 3) == 0);
  endtask

  // Append a point and remember its time for shaping later queries.
  task automatic load_point(logic [DataW-1:0] t, logic [DataW-1:0] p);
    send(OP_LOAD, t, p);
    if (point_time.size() < MaxPoints) point_time = {point_time, int'(t)};
  endtask

  // Grow the table mostly in ascending time; sometimes repeat a time or step back.
  task automatic add_point();
    int               inc;
    int unsigned      roll;
    logic [DataW-1:0] p;
    roll = $urandom_range(0, 99);
    if (roll < 10)      inc = 0;
    else if (roll < 15) inc = -int'($urandom_range(1, 32'h1_0000));
    else                inc = $urandom_range(1, 32'h4_0000);
    if ($urandom_range(0, 3) == 0) p = $urandom();
    else                           p = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
    load_point(point_time[$] + inc, p);
  endtask

  // Drop valid, drain every outstanding result, then let the block settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_enable(logic v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed traffic: a few loads, then an ascending sweep of queries
  // over the table with occasional backward steps and extrapolation. The rest is
  // fully random queries, hits on stored times and out-of-order loads.
  task automatic run_mix(int n);
    int          start, span, qt, nq, nl, idx;
    int unsigned roll;
    start = items_sent;
    while (items_sent - start < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        nl = $urandom_range(0, 3);
        repeat (nl) begin
          if (point_time.size() < MaxPoints || $urandom_range(0, 3) == 0) add_point();
        end
        span = point_time[$] - point_time[0];
        if (span < 32'h1_0000) span = 32'h1_0000;
        qt = point_time[0] - 32'h8000 + int'($urandom_range(0, span / 4));
        nq = $urandom_range(3, 10);
        repeat (nq) begin
          send(OP_QUERY, qt, $urandom());
          roll = $urandom_range(0, 15);
          if (roll == 0)      qt = qt - int'($urandom_range(0, span / 4));
          else if (roll == 1) qt = point_time[$] + int'($urandom_range(1, 32'h100_0000));
          else                qt = qt + int'($urandom_range(0, span / 3 + 32'h1_0000));
        end
      end else if (roll < 90) begin
        send(OP_QUERY, $urandom(), $urandom());
      end else if (roll < 96) begin
        idx = $urandom_range(0, point_time.size() - 1);
        send(OP_QUERY, point_time[idx], $urandom());
      end else begin
        // out-of-order point with unconstrained pressure
        load_point(point_time[$] - int'($urandom_range(0, 32'h2_0000)), $urandom());
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty and one-point tables, disabled, before start, equal
    // times, extrapolation with saturation both ways, query behind the cursor.
    send(OP_QUERY, 32'h0001_0000, 32'hFFFF_FFFF);
    load_point(32'hFFFF_0000, 32'h0000_0000);
    send(OP_QUERY, 32'h0000_0000, 32'h0000_0000);
    write_enable(1'b0);
    send(OP_QUERY, 32'h0000_0000, 32'h0000_0000);
    write_enable(1'b1);
    load_point(32'h0001_0000, 32'h0002_0000);
    send(OP_QUERY, 32'h8000_0000, 32'h0000_0000);
    send(OP_QUERY, 32'hFFFF_0000, 32'h8000_0000);
    send(OP_QUERY, 32'h0000_0000, 32'h7FFF_FFFF);
    send(OP_QUERY, 32'h7FFF_FFFF, 32'h0000_0000);
    load_point(32'h0001_0000, 32'h7FFF_FFFF);
    send(OP_QUERY, 32'h0002_0000, 32'h0000_0000);
    load_point(32'h0003_0000, 32'h8000_0000);
    send(OP_QUERY, 32'h0002_8000, 32'h0000_0000);
    send(OP_QUERY, 32'h0000_8000, 32'h0000_0000);
    send(OP_QUERY, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

    // Random phases; enable toggles between phases only, while the block is idle.
    for (int ph = 0; ph < 6; ph++) begin
      write_enable((ph == 1 || ph == 4) ? 1'b0 : 1'b1);
      if (ph == 5) begin
        // fill the table and push a few loads past capacity
        while (point_time.size() < MaxPoints) add_point();
        repeat (3) add_point();
      end
      run_mix(ph == 0 ? 400 : ((ph == 1 || ph == 4) ? 50 : 230));
    end

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: random hold-off per result, calm stretches, and one long stall
  // mid-run so the block backs up and stops taking input.
  initial begin
    int gap;
    int served;
    int hold_at;
    bit calm;
    served  = 0;
    calm    = 1'b0;
    hold_at = 150;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (served == hold_at) begin
        out_ready <= 1'b0;
        repeat (600) @(negedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      served++;
      if (served % 50 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #25_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
